[src/ghash_pkg.sv]
`default_nettype none

package ghash_pkg;

   localparam int unsigned BLOCK_WIDTH     = 128;
   localparam int unsigned HALF_WIDTH      = 64;
   localparam int unsigned COUNT_WIDTH     = 5;
   localparam int unsigned BLOCK_BYTES     = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 64;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HASH_KEY_HI = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HASH_KEY_LO = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TAG_MASK_HI = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TAG_MASK_LO = 2'd3;

   typedef enum logic {
      ACTION_ABSORB = 1'b0,
      ACTION_DIGEST = 1'b1
   } action_type;

   // one classified item, as it sits in the queue
   typedef struct packed {
      action_type             action;
      logic [BLOCK_WIDTH-1:0] block;
   } entry_type;

   typedef struct packed {
      logic                       write_enable;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_DATA_WIDTH-1:0]  wdata;
   } csr_write_type;

   // queue status towards front and back
   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

`default_nettype wire

[src/ghash_front.sv]
`default_nettype none

module ghash_front (
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic                                    req_action,
   input  wire logic [ghash_pkg::HALF_WIDTH-1:0]        req_block_hi,
   input  wire logic [ghash_pkg::HALF_WIDTH-1:0]        req_block_lo,
   input  wire logic [ghash_pkg::COUNT_WIDTH-1:0]       req_byte_count,
   input  wire ghash_pkg::queue_status_type             queue_status,
   output logic                                         push,
   output ghash_pkg::entry_type                         push_entry
);

   logic [ghash_pkg::COUNT_WIDTH-1:0] count_sat;
   logic [ghash_pkg::BLOCK_WIDTH-1:0] block_raw;
   logic [ghash_pkg::BLOCK_WIDTH-1:0] block_masked;

   assign req_stall = queue_status.full;
   assign push      = req_valid & ~queue_status.full;
   assign block_raw = {req_block_hi, req_block_lo};

   // counts past a whole block keep all sixteen bytes
   assign count_sat = (req_byte_count > ghash_pkg::COUNT_WIDTH'(ghash_pkg::BLOCK_BYTES))
                      ? ghash_pkg::COUNT_WIDTH'(ghash_pkg::BLOCK_BYTES) : req_byte_count;

   // byte 0 is the top byte; bytes at and past the count are zeroed
   always_comb begin
      for (int b = 0; b < ghash_pkg::BLOCK_BYTES; b++) begin
         block_masked[ghash_pkg::BLOCK_WIDTH-1-8*b -: 8] =
            (ghash_pkg::COUNT_WIDTH'(b) < count_sat)
            ? block_raw[ghash_pkg::BLOCK_WIDTH-1-8*b -: 8] : 8'h00;
      end
   end

   assign push_entry.action = ghash_pkg::action_type'(req_action);
   assign push_entry.block  = block_masked;

endmodule

`default_nettype wire

[src/ghash_queue.sv]
`default_nettype none

module ghash_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire ghash_pkg::entry_type        push_entry,
   input  wire logic                        pop,
   output ghash_pkg::entry_type             head_entry,
   output ghash_pkg::queue_status_type      status
);

   localparam int unsigned PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CountWidth = $clog2(DEPTH + 1);

   ghash_pkg::entry_type    store_ff [DEPTH];
   logic [PtrWidth-1:0]     wptr_ff, wptr_in;
   logic [PtrWidth-1:0]     rptr_ff, rptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;

   assign status.full      = (count_ff == CountWidth'(DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign head_entry       = store_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

[src/ghash_back.sv]
`default_nettype none

module ghash_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire ghash_pkg::csr_write_type            csr_write,
   input  wire ghash_pkg::entry_type                head_entry,
   input  wire ghash_pkg::queue_status_type         queue_status,
   output logic                                     pop,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [ghash_pkg::HALF_WIDTH-1:0]         rsp_tag_hi,
   output logic [ghash_pkg::HALF_WIDTH-1:0]         rsp_tag_lo
);

   // carry-less product and reduction by x^128 + x^7 + x^2 + x + 1,
   // bit 0 of the polynomial being the top bit of the word
   function automatic logic [127:0] gf_mul(input logic [127:0] x, input logic [127:0] y);
      logic [254:0] prod;
      logic [126:0] high;
      logic [133:0] fold;
      logic [5:0]   over;
      logic [127:0] poly;
      logic [127:0] res;
      prod = '0;
      for (int i = 0; i < 128; i++) begin
         for (int j = 0; j < 128; j++) begin
            prod[i+j] = prod[i+j] ^ (x[127-i] & y[127-j]);
         end
      end
      high = prod[254:128];
      fold = {6'b0, prod[127:0]} ^ {7'b0, high} ^ {6'b0, high, 1'b0}
           ^ {5'b0, high, 2'b0} ^ {high, 7'b0};
      over = fold[133:128];
      poly = fold[127:0] ^ {122'b0, over} ^ {121'b0, over, 1'b0}
           ^ {120'b0, over, 2'b0} ^ {115'b0, over, 7'b0};
      for (int k = 0; k < 128; k++) begin
         res[127-k] = poly[k];
      end
      return res;
   endfunction

   logic [ghash_pkg::HALF_WIDTH-1:0]  key_hi_ff, key_lo_ff;
   logic [ghash_pkg::HALF_WIDTH-1:0]  mask_hi_ff, mask_lo_ff;
   logic [ghash_pkg::BLOCK_WIDTH-1:0] accum_ff, accum_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [ghash_pkg::BLOCK_WIDTH-1:0] tag_ff, tag_in;
   logic                              out_free;
   logic                              is_digest;
   logic [ghash_pkg::BLOCK_WIDTH-1:0] masked;

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign is_digest = (head_entry.action == ghash_pkg::ACTION_DIGEST);
   assign pop       = queue_status.not_empty & (~is_digest | out_free);
   assign masked    = accum_ff ^ {mask_hi_ff, mask_lo_ff};

   always_comb begin
      accum_in     = accum_ff;
      tag_in       = tag_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (pop) begin
         if (is_digest) begin
            accum_in     = masked;
            tag_in       = masked;
            rsp_valid_in = 1'b1;
         end else begin
            accum_in = gf_mul(head_entry.block ^ accum_ff, {key_hi_ff, key_lo_ff});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff    <= '0;
         key_lo_ff    <= '0;
         mask_hi_ff   <= '0;
         mask_lo_ff   <= '0;
         accum_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         accum_ff     <= accum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write.write_enable) begin
            unique case (csr_write.index)
               ghash_pkg::CSR_HASH_KEY_HI: key_hi_ff  <= csr_write.wdata;
               ghash_pkg::CSR_HASH_KEY_LO: key_lo_ff  <= csr_write.wdata;
               ghash_pkg::CSR_TAG_MASK_HI: mask_hi_ff <= csr_write.wdata;
               ghash_pkg::CSR_TAG_MASK_LO: mask_lo_ff <= csr_write.wdata;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_tag_hi = tag_ff[ghash_pkg::BLOCK_WIDTH-1 -: ghash_pkg::HALF_WIDTH];
   assign rsp_tag_lo = tag_ff[ghash_pkg::HALF_WIDTH-1:0];

endmodule

`default_nettype wire

[src/ghash_accumulator_top.sv]
`default_nettype none

// GCM GHASH accumulator. Each req item either absorbs a 128-bit block
// (action 0) or asks for the tag (action 1). An absorbed block keeps its
// first byte_count bytes (byte 0 is the top byte of req_block_hi; counts
// above 16 mean the whole block), is XORed into the accumulator and the sum
// is multiplied by the hash key H in GF(2^128) with the reflected GCM bit
// order. A digest XORs the tag mask into the accumulator, keeps that value
// and returns it on rsp as the tag; absorb items give no rsp item. The
// block takes one item per cycle while no held tag stops it: the front
// masks and queues items, the back retires one item each cycle, and the
// combinational GF(2^128) multiply in the back, whose result feeds the next
// block, sets the clock. A digest's tag is registered on rsp once it leaves
// the queue. A tag held on rsp stops the back at the next digest; once the
// queue is full, req_stall rises. The user must write registers H and the
// mask through csr_ only while no item is in flight; the block does not enforce it.

module ghash_accumulator_top #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   // configuration
   input  wire logic                                      csr_write_enable,
   input  wire logic [ghash_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [ghash_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata,
   // request items
   input  wire logic                                      req_valid,
   output logic                                           req_stall,
   input  wire logic                                      req_action,
   input  wire logic [ghash_pkg::HALF_WIDTH-1:0]          req_block_hi,
   input  wire logic [ghash_pkg::HALF_WIDTH-1:0]          req_block_lo,
   input  wire logic [ghash_pkg::COUNT_WIDTH-1:0]         req_byte_count,
   // tag items
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_stall,
   output logic [ghash_pkg::HALF_WIDTH-1:0]               rsp_tag_hi,
   output logic [ghash_pkg::HALF_WIDTH-1:0]               rsp_tag_lo
);

   ghash_pkg::csr_write_type     csr_write;
   ghash_pkg::queue_status_type  queue_status;
   ghash_pkg::entry_type         push_entry;
   ghash_pkg::entry_type         head_entry;
   logic                         push;
   logic                         pop;

   assign csr_write.write_enable = csr_write_enable;
   assign csr_write.index        = csr_index;
   assign csr_write.wdata        = csr_wdata;

   // front: byte masking, stalls only on a full queue
   ghash_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_block_hi   (req_block_hi),
      .req_block_lo   (req_block_lo),
      .req_byte_count (req_byte_count),
      .queue_status   (queue_status),
      .push           (push),
      .push_entry     (push_entry)
   );

   // short queue parting front and back
   ghash_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (queue_status)
   );

   // back: accumulator, key multiply, tag register
   ghash_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_write),
      .head_entry   (head_entry),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_tag_hi   (rsp_tag_hi),
      .rsp_tag_lo   (rsp_tag_lo)
   );

endmodule

`default_nettype wire
